@@ hdl/pmq_pkg.sv @@
// Shared types and constants of the four-level priority message queue.
// No dependencies; pmq_ctrl and the top level use it by scoped names.
package pmq_pkg;

    localparam int DEPTH      = 64;
    localparam int BODY_WIDTH = 32;
    localparam int LEVELS     = 4;
    localparam int LVL_W      = 2;
    localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ADDR_W     = LVL_W + PTR_W;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CAP_W      = 7;
    localparam int CMP_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int ID_W       = 32;
    localparam int KEEP_W     = (BODY_WIDTH < 32) ? BODY_WIDTH : 32;

    localparam logic [LVL_W-1:0] LVL_URGENT  = LVL_W'(3);
    localparam logic [LVL_W-1:0] LVL_DEFAULT = LVL_W'(1);
    localparam logic [CAP_W-1:0] CAP_RESET   = CAP_W'(64);

    typedef enum logic {
        ACT_SEND = 1'b0,
        ACT_RECV = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic        action;
        logic [2:0]  priority_req;
        logic [7:0]  sender;
        logic [31:0] payload;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_message_id;
        logic [7:0]  out_sender;
        logic [2:0]  out_priority;
        logic [31:0] out_payload;
        logic [6:0]  occupancy;
    } res_t;

    // One stored message: tag and body.
    typedef struct packed {
        logic [2:0]        prio;
        logic [7:0]        sender;
        logic [ID_W-1:0]   id;
        logic [KEEP_W-1:0] body;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        entry_t            wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        status_t         status;
        logic [ID_W-1:0] id;
        logic [6:0]      occupancy;
        logic            recv_ok;
    } step_t;

endpackage

@@ hdl/pmq_ram.sv @@
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module pmq_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 75
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/pmq_ctrl.sv @@
// Level pointers, counts, id counter and capacity register; picks the
// level for each beat and drives the message RAM. Uses pmq_pkg.
module pmq_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [6:0]              cfg_wr_data,
    input  logic                    go,
    input  pmq_pkg::cmd_t           cmd,
    output pmq_pkg::mem_req_t       mem_req,
    output pmq_pkg::step_t          step
);

    logic [pmq_pkg::PTR_W-1:0] head_reg  [pmq_pkg::LEVELS];
    logic [pmq_pkg::PTR_W-1:0] head_next [pmq_pkg::LEVELS];
    logic [pmq_pkg::PTR_W-1:0] tail_reg  [pmq_pkg::LEVELS];
    logic [pmq_pkg::PTR_W-1:0] tail_next [pmq_pkg::LEVELS];
    logic [pmq_pkg::CNT_W-1:0] count_reg [pmq_pkg::LEVELS];
    logic [pmq_pkg::CNT_W-1:0] count_next[pmq_pkg::LEVELS];
    logic [pmq_pkg::CNT_W-1:0] total_reg;
    logic [pmq_pkg::CNT_W-1:0] total_next;
    logic [pmq_pkg::ID_W-1:0]  id_reg;
    logic [pmq_pkg::ID_W-1:0]  id_next;
    logic [pmq_pkg::CAP_W-1:0] cap_reg;

    logic                      full;
    logic                      found;
    logic [pmq_pkg::LVL_W-1:0] send_lvl;
    logic [pmq_pkg::LVL_W-1:0] recv_lvl;

    function automatic logic [pmq_pkg::PTR_W-1:0] ptr_inc(
        input logic [pmq_pkg::PTR_W-1:0] p
    );
        logic [pmq_pkg::PTR_W-1:0] r;
        if (p == pmq_pkg::PTR_W'(pmq_pkg::DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    // Capacity above DEPTH acts as DEPTH.
    assign full = (pmq_pkg::CMP_W'(total_reg) >= pmq_pkg::CMP_W'(cap_reg))
               || (pmq_pkg::CMP_W'(total_reg) >= pmq_pkg::CMP_W'(pmq_pkg::DEPTH));

    assign send_lvl = cmd.priority_req[2] ? pmq_pkg::LVL_DEFAULT
                                          : cmd.priority_req[pmq_pkg::LVL_W-1:0];

    // Highest non-empty level wins.
    always_comb
    begin
        found    = 1'b0;
        recv_lvl = '0;
        for (int i = pmq_pkg::LEVELS - 1; i >= 0; i--)
        begin
            if (!found && (count_reg[i] != '0))
            begin
                found    = 1'b1;
                recv_lvl = pmq_pkg::LVL_W'(i);
            end
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        total_next = total_reg;
        id_next    = id_reg;

        mem_req.we           = 1'b0;
        mem_req.waddr        = {send_lvl, tail_reg[send_lvl]};
        mem_req.wdata.prio   = cmd.priority_req;
        mem_req.wdata.sender = cmd.sender;
        mem_req.wdata.id     = id_reg;
        mem_req.wdata.body   = cmd.payload[pmq_pkg::KEEP_W-1:0];
        mem_req.re           = 1'b0;
        mem_req.raddr        = {recv_lvl, head_reg[recv_lvl]};

        step.status  = pmq_pkg::STAT_DONE;
        step.id      = '0;
        step.recv_ok = 1'b0;

        unique case (pmq_pkg::action_t'(cmd.action))
            pmq_pkg::ACT_SEND:
            begin
                id_next = id_reg + 1'b1;
                step.id = id_reg;
                if (full)
                begin
                    step.status = pmq_pkg::STAT_FULL;
                end
                else
                begin
                    mem_req.we           = go;
                    tail_next[send_lvl]  = ptr_inc(tail_reg[send_lvl]);
                    count_next[send_lvl] = count_reg[send_lvl] + 1'b1;
                    total_next           = total_reg + 1'b1;
                end
            end
            pmq_pkg::ACT_RECV:
            begin
                if (!found)
                begin
                    step.status = pmq_pkg::STAT_EMPTY;
                end
                else
                begin
                    // Id comes from the RAM read, merged at the output.
                    mem_req.re           = go;
                    step.recv_ok         = 1'b1;
                    head_next[recv_lvl]  = ptr_inc(head_reg[recv_lvl]);
                    count_next[recv_lvl] = count_reg[recv_lvl] - 1'b1;
                    total_next           = total_reg - 1'b1;
                end
            end
            default:
            begin
                step.status = pmq_pkg::STAT_DONE;
            end
        endcase

        step.occupancy = 7'(total_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pmq_pkg::LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            total_reg <= '0;
            id_reg    <= pmq_pkg::ID_W'(1);
        end
        else if (go)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            total_reg <= total_next;
            id_reg    <= id_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= pmq_pkg::CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            cap_reg <= cfg_wr_data;
        end
    end

endmodule

@@ hdl/four_level_priority_message_queue.sv @@
// Top level of the four-level priority message queue: input register,
// result register and the message RAM. Uses pmq_pkg, pmq_ctrl, pmq_ram.
//
//  channel   signals                          dir  beat
//  cmd       cmd_valid, cmd_ready, cmd        in   one send or receive
//  res       res_valid, res_ready, res        out  one result per cmd beat
//  config    cfg_wr_en, cfg_wr_data           in   capacity write, no wait
//
// A cmd beat lands in the input register and is processed when it advances
// (pointer update plus one RAM write or read); its result then waits in the
// result register until taken on res. One beat per cycle is sustained while
// res_ready is high. Reset empties all levels, sets the next id to one and
// capacity to 64; the RAM needs no clearing. A stalled res holds the pipe;
// cmd_ready drops only when the input register is full and cannot advance.
module four_level_priority_message_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  pmq_pkg::cmd_t  cmd,
    output logic           res_valid,
    input  logic           res_ready,
    output pmq_pkg::res_t  res,
    input  logic           cfg_wr_en,
    input  logic [6:0]     cfg_wr_data
);

    pmq_pkg::cmd_t     cmd_reg;
    logic              cmd_valid_reg;
    pmq_pkg::step_t    step_reg;
    logic              res_valid_reg;
    pmq_pkg::step_t    step;
    pmq_pkg::mem_req_t mem_req;
    pmq_pkg::entry_t   rd_entry;
    logic [pmq_pkg::ENTRY_W-1:0] rd_bits;
    logic              go;

    // Advance when the result register is free or being drained.
    assign go        = cmd_valid_reg && (!res_valid_reg || res_ready);
    assign cmd_ready = !cmd_valid_reg || go;

    pmq_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .go          (go),
        .cmd         (cmd_reg),
        .mem_req     (mem_req),
        .step        (step)
    );

    pmq_ram #(
        .ADDR_W (pmq_pkg::ADDR_W),
        .DATA_W (pmq_pkg::ENTRY_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (rd_bits)
    );

    assign rd_entry = pmq_pkg::entry_t'(rd_bits);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_ready)
            begin
                cmd_valid_reg <= cmd_valid;
            end
            if (go)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_ready && cmd_valid)
        begin
            cmd_reg <= cmd;
        end
        if (go)
        begin
            step_reg <= step;
        end
    end

    // Merge the registered RAM data; otherwise give the step's id and zero the other message fields.
    always_comb
    begin
        res.status    = step_reg.status;
        res.occupancy = step_reg.occupancy;
        if (step_reg.recv_ok)
        begin
            res.out_message_id = rd_entry.id;
            res.out_sender     = rd_entry.sender;
            res.out_priority   = rd_entry.prio;
            res.out_payload    = 32'(rd_entry.body);
        end
        else
        begin
            res.out_message_id = step_reg.id;
            res.out_sender     = '0;
            res.out_priority   = '0;
            res.out_payload    = '0;
        end
    end

    assign res_valid = res_valid_reg;

endmodule

@@ test/four_level_priority_message_queue_tb.sv @@
// Testbench for four_level_priority_message_queue: queued cmd beats, a priority-queue
// predictor, and a res monitor that checks each result field, over several capacity settings.
// Depends on pmq_pkg and the hdl sources of the block.
`timescale 1ns / 100ps

module four_level_priority_message_queue_tb;

    localparam int HALF_PERIOD = 5;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_WAIT = 4;
    localparam int HOLD_LEN = 400;
    localparam int NUM_LEVELS = 4;

    typedef struct packed {
        logic [31:0] id;
        logic [7:0]  src;
        logic [2:0]  prio;
        logic [31:0] body;
    } msg_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            cmd_valid = 1'b0;
    logic            cmd_ready;
    pmq_pkg::cmd_t   cmd = '0;
    logic            res_valid;
    logic            res_ready = 1'b0;
    pmq_pkg::res_t   res;
    logic            cfg_wr_en = 1'b0;
    logic [6:0]      cfg_wr_data = '0;

    // Stimulus and scoreboard
    pmq_pkg::cmd_t pending_cmds[$];
    pmq_pkg::res_t awaited_replies[$];
    pmq_pkg::res_t want_reply;
    int   mismatches = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_reqs = 0;
    int   hold_taken = 0;
    int   hold_cycles = 0;

    // Shadow of the queue contents
    msg_t        held_msgs[NUM_LEVELS][$];
    int          held_total = 0;
    logic [31:0] next_msg_id = 32'd1;
    logic [6:0]  capacity_shadow = pmq_pkg::CAP_RESET;

    four_level_priority_message_queue dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic pmq_pkg::res_t compute_reply(pmq_pkg::cmd_t c);
        pmq_pkg::res_t r;
        msg_t m;
        int   lvl;
        int   limit;
        bit   found;
        r = '0;
        if (c.action == pmq_pkg::ACT_SEND)
        begin
            r.out_message_id = next_msg_id;
            next_msg_id = next_msg_id + 32'd1;
            limit = (capacity_shadow > pmq_pkg::DEPTH) ? pmq_pkg::DEPTH
                                                       : int'(capacity_shadow);
            if (held_total >= limit)
                r.status = pmq_pkg::STAT_FULL;
            else
            begin
                // file out-of-range priorities at the default level
                lvl = (c.priority_req > 3'(pmq_pkg::LVL_URGENT))
                    ? int'(pmq_pkg::LVL_DEFAULT) : int'(c.priority_req);
                m.id = r.out_message_id;
                m.src = c.sender;
                m.prio = c.priority_req;
                m.body = c.payload;
                held_msgs[lvl].push_back(m);
                held_total++;
            end
        end
        else
        begin
            found = 1'b0;
            lvl = int'(pmq_pkg::LVL_URGENT);
            while (!found && lvl >= 0)
            begin
                if (held_msgs[lvl].size() != 0)
                    found = 1'b1;
                else
                    lvl--;
            end
            if (!found)
                r.status = pmq_pkg::STAT_EMPTY;
            else
            begin
                m = held_msgs[lvl].pop_front();
                held_total--;
                r.out_message_id = m.id;
                r.out_sender = m.src;
                r.out_priority = m.prio;
                r.out_payload = m.body;
            end
        end
        r.occupancy = 7'(held_total);
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            mismatches++;
        end
    endfunction

    function automatic pmq_pkg::cmd_t make_cmd(pmq_pkg::action_t a, int prio, int src,
                                               logic [31:0] body);
        pmq_pkg::cmd_t c;
        c.action = a;
        c.priority_req = 3'(prio);
        c.sender = 8'(src);
        c.payload = body;
        return c;
    endfunction

    // Driver: hold the beat until accepted, then advance or idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd <= '0;
        end
        else
        begin
            if (cmd_valid && cmd_ready)
                awaited_replies.push_back(compute_reply(cmd));
            if (!cmd_valid || cmd_ready)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cmd_valid <= 1'b1;
                    cmd <= pending_cmds.pop_front();
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each res beat with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else
        begin
            if (res_valid && res_ready)
            begin
                if (awaited_replies.size() == 0)
                begin
                    $error("res beat with no command outstanding");
                    mismatches++;
                end
                else
                begin
                    want_reply = awaited_replies.pop_front();
                    check_field("status", 32'(want_reply.status), 32'(res.status));
                    check_field("out_message_id", want_reply.out_message_id,
                                res.out_message_id);
                    check_field("out_sender", 32'(want_reply.out_sender), 32'(res.out_sender));
                    check_field("out_priority", 32'(want_reply.out_priority),
                                32'(res.out_priority));
                    check_field("out_payload", want_reply.out_payload, res.out_payload);
                    check_field("occupancy", 32'(want_reply.occupancy), 32'(res.occupancy));
                end
            end
            res_ready <= (hold_cycles == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off, started on request
    always @(posedge clk)
    begin
        if (hold_cycles != 0)
            hold_cycles <= hold_cycles - 1;
        else if (hold_taken != hold_reqs)
        begin
            hold_cycles <= HOLD_LEN;
            hold_taken <= hold_taken + 1;
        end
    end

    task automatic wait_drain();
        @(negedge clk);
        while (pending_cmds.size() != 0 || cmd_valid || awaited_replies.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_capacity(logic [6:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        capacity_shadow = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic queue_random(int count);
        int send_pct;
        pmq_pkg::cmd_t c;
        send_pct = 50;
        for (int i = 0; i < count; i++)
        begin
            // shift the send/receive mix in bursts so levels fill and drain
            if (i % 20 == 0)
            begin
                case ($urandom_range(2))
                    0: send_pct = 15;
                    1: send_pct = 50;
                    default: send_pct = 85;
                endcase
            end
            c.action = ($urandom_range(99) < send_pct) ? pmq_pkg::ACT_SEND : pmq_pkg::ACT_RECV;
            c.priority_req = 3'($urandom_range(7));
            c.sender = 8'($urandom_range(255));
            c.payload = $urandom();
            pending_cmds.push_back(c);
        end
    endtask

    task automatic random_phase(logic [6:0] cap, int s_idle, int r_stall, int count,
                                bit long_hold);
        write_capacity(cap);
        send_idle_pct = s_idle;
        recv_stall_pct = r_stall;
        if (long_hold)
            hold_reqs++;
        queue_random(count);
        wait_drain();
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset capacity: empty receive, every level and two out-of-range priorities, field extremes, level order
        pending_cmds.push_back(make_cmd(pmq_pkg::ACT_RECV, 0, 0, 32'h0));
        pending_cmds.push_back(make_cmd(pmq_pkg::ACT_SEND, 3, 0, 32'h0000_0000));
        pending_cmds.push_back(make_cmd(pmq_pkg::ACT_SEND, 0, 255, 32'hFFFF_FFFF));
        pending_cmds.push_back(make_cmd(pmq_pkg::ACT_SEND, 7, 1, 32'h5A5A_5A5A));
        pending_cmds.push_back(make_cmd(pmq_pkg::ACT_SEND, 2, 8'h80, 32'h0000_0001));
        pending_cmds.push_back(make_cmd(pmq_pkg::ACT_SEND, 4, 8'h7F, 32'h8000_0000));
        pending_cmds.push_back(make_cmd(pmq_pkg::ACT_SEND, 1, 8'h3C, 32'hA5A5_A5A5));
        repeat (3) pending_cmds.push_back(make_cmd(pmq_pkg::ACT_RECV, 7, 255, 32'hFFFF_FFFF));
        wait_drain();

        // Capacity lowered below occupancy
        write_capacity(7'd2);
        pending_cmds.push_back(make_cmd(pmq_pkg::ACT_SEND, 3, 9, 32'h1111_1111));
        pending_cmds.push_back(make_cmd(pmq_pkg::ACT_RECV, 0, 0, 32'h0));
        pending_cmds.push_back(make_cmd(pmq_pkg::ACT_SEND, 0, 10, 32'h2222_2222));
        pending_cmds.push_back(make_cmd(pmq_pkg::ACT_RECV, 0, 0, 32'h0));
        pending_cmds.push_back(make_cmd(pmq_pkg::ACT_SEND, 5, 11, 32'h3333_3333));
        wait_drain();

        // Zero capacity rejects every send
        write_capacity(7'd0);
        pending_cmds.push_back(make_cmd(pmq_pkg::ACT_SEND, 3, 12, 32'h4444_4444));
        repeat (3) pending_cmds.push_back(make_cmd(pmq_pkg::ACT_RECV, 0, 0, 32'h0));
        wait_drain();

        // Capacity above the pool size
        write_capacity(7'd127);
        pending_cmds.push_back(make_cmd(pmq_pkg::ACT_SEND, 3, 13, 32'hDEAD_BEEF));
        pending_cmds.push_back(make_cmd(pmq_pkg::ACT_SEND, 6, 14, 32'hCAFE_F00D));
        repeat (2) pending_cmds.push_back(make_cmd(pmq_pkg::ACT_RECV, 0, 0, 32'h0));
        wait_drain();

        random_phase(7'd64, 0, 0, 400, 1'b0);
        random_phase(7'd64, 84, 0, 200, 1'b0);
        random_phase(7'd5, 0, 84, 200, 1'b0);
        random_phase(7'd1, 17, 17, 150, 1'b0);
        random_phase(7'd100, 0, 0, 250, 1'b1);
        random_phase(7'd64, 17, 17, 300, 1'b0);
        random_phase(7'd0, 0, 0, 50, 1'b0);
        random_phase(7'd33, 0, 84, 150, 1'b0);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
